### rtl/core/rv64i_integer_execute_macros.svh
// ----------------------------------------------------------------------------
// rv64i integer execute - assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RV64I_INTEGER_EXECUTE_MACROS_SVH
`define RV64I_INTEGER_EXECUTE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RV64IE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define RV64IE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define RV64IE_ASSERT(lbl, prop, msg)

`define RV64IE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/core/rv64ie_pkg.sv
// ----------------------------------------------------------------------------
// rv64ie_pkg
// shared constants, opcode and function codes, and result type
// ----------------------------------------------------------------------------
package rv64ie_pkg;

    localparam int NUM_REGS = 32;
    localparam int REG_AW   = $clog2(NUM_REGS);
    localparam int XLEN     = 64;

    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OP_32  = 7'h3b;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_JALR = 3'd0;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [5:0] SHIFT_HI_LOGIC = 6'h00;
    localparam logic [5:0] SHIFT_HI_ARITH = 6'h10;

    typedef struct packed {
        logic [4:0]      dest_index;
        logic            dest_write;
        logic [XLEN-1:0] dest_value;
        logic [XLEN-1:0] next_address;
        logic            branch_taken;
        logic            illegal;
    } exe_result_t;

    function automatic logic reg_out_of_range(input logic [4:0] idx);
        return (32'(idx) >= NUM_REGS);
    endfunction

endpackage

### rtl/core/rv64ie_regfile.sv
// ----------------------------------------------------------------------------
// rv64ie_regfile
// integer register file, two registered reads, one write, write-through bypass
// ----------------------------------------------------------------------------
`include "rv64i_integer_execute_macros.svh"

module rv64ie_regfile (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [rv64ie_pkg::REG_AW-1:0] rs1_addr,
    input  logic [rv64ie_pkg::REG_AW-1:0] rs2_addr,
    input  logic                          wr_en,
    input  logic [rv64ie_pkg::REG_AW-1:0] wr_addr,
    input  logic [rv64ie_pkg::XLEN-1:0]   wr_data,
    output logic [rv64ie_pkg::XLEN-1:0]   rs1_data,
    output logic [rv64ie_pkg::XLEN-1:0]   rs2_data
);
    import rv64ie_pkg::*;

    logic [XLEN-1:0]     mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [XLEN-1:0]     rdata1_reg;
    logic [XLEN-1:0]     rdata2_reg;
    logic                rvld1_reg;
    logic                rvld2_reg;
    logic                hit1;
    logic                hit2;

    assign hit1 = wr_en && (wr_addr == rs1_addr);
    assign hit2 = wr_en && (wr_addr == rs2_addr);

    // entries not yet written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            rvld1_reg <= 1'b0;
            rvld2_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld1_reg <= hit1 || vld_reg[rs1_addr];
                rvld2_reg <= hit2 || vld_reg[rs2_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata1_reg <= hit1 ? wr_data : mem[rs1_addr];
            rdata2_reg <= hit2 ? wr_data : mem[rs2_addr];
        end
    end

    assign rs1_data = rvld1_reg ? rdata1_reg : '0;
    assign rs2_data = rvld2_reg ? rdata2_reg : '0;

    `RV64IE_ASSERT(a_no_x0_write, wr_en |-> (wr_addr != '0), "write to x0")
    `RV64IE_ASSERT(a_x0_never_valid, !vld_reg[0], "x0 marked as written")
    `RV64IE_ASSERT_NEXT(a_bypass1, rd_en && hit1, rs1_data == $past(wr_data), "rs1 bypass lost")

endmodule

### rtl/core/rv64ie_alu.sv
// ----------------------------------------------------------------------------
// rv64ie_alu
// decode and execute of one instruction: alu, branch compare, target, legality
// ----------------------------------------------------------------------------
module rv64ie_alu (
    input  logic [31:0]                   instruction,
    input  logic [rv64ie_pkg::XLEN-1:0]   pc,
    input  logic [rv64ie_pkg::XLEN-1:0]   rs1_data,
    input  logic [rv64ie_pkg::XLEN-1:0]   rs2_data,
    output rv64ie_pkg::exe_result_t       result
);
    import rv64ie_pkg::*;

    logic [6:0]      opc;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [4:0]      rd;
    logic [4:0]      r1;
    logic [4:0]      r2;
    logic [5:0]      hi6;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] immi;
    logic [XLEN-1:0] immb;
    logic [XLEN-1:0] immj;
    logic [XLEN-1:0] immu;
    logic [XLEN-1:0] opb;
    logic [5:0]      shamt;
    logic [XLEN-1:0] sum;
    logic [XLEN-1:0] diff;
    logic [XLEN-1:0] pc_plus4;
    logic            lt_s;
    logic            lt_u;
    logic [31:0]     w_sum;
    logic [31:0]     w_diff;
    logic [31:0]     w_sll;
    logic [31:0]     w_srl;
    logic [31:0]     w_sra;
    logic            ok;
    logic            wr;
    logic            use1;
    logic            use2;
    logic            taken;
    logic            cond;
    logic [XLEN-1:0] val;
    logic [XLEN-1:0] next;

    assign opc   = instruction[6:0];
    assign f3    = instruction[14:12];
    assign f7    = instruction[31:25];
    assign rd    = instruction[11:7];
    assign r1    = instruction[19:15];
    assign r2    = instruction[24:20];
    assign hi6   = instruction[31:26];
    assign a     = rs1_data;
    assign b     = rs2_data;

    assign immi  = {{52{instruction[31]}}, instruction[31:20]};
    assign immb  = {{51{instruction[31]}}, instruction[31], instruction[7],
                    instruction[30:25], instruction[11:8], 1'b0};
    assign immj  = {{43{instruction[31]}}, instruction[31], instruction[19:12],
                    instruction[20], instruction[30:21], 1'b0};
    assign immu  = {{32{instruction[31]}}, instruction[31:12], 12'h000};

    // immediate or register second operand
    assign opb      = (opc == OPC_OP_IMM || opc == OPC_JALR) ? immi : b;
    assign shamt    = opb[5:0];
    assign sum      = a + opb;
    assign diff     = a - b;
    assign pc_plus4 = pc + 64'd4;
    assign lt_s     = $signed(a) < $signed(opb);
    assign lt_u     = a < opb;

    assign w_sum  = a[31:0] + b[31:0];
    assign w_diff = a[31:0] - b[31:0];
    assign w_sll  = a[31:0] << b[4:0];
    assign w_srl  = a[31:0] >> b[4:0];
    assign w_sra  = 32'($signed(a[31:0]) >>> b[4:0]);

    always_comb
    begin
        ok    = 1'b1;
        wr    = 1'b0;
        use1  = 1'b0;
        use2  = 1'b0;
        taken = 1'b0;
        cond  = 1'b0;
        val   = '0;
        next  = pc_plus4;
        case (opc)
            OPC_OP_IMM:
            begin
                use1 = 1'b1;
                wr   = 1'b1;
                case (f3)
                    F3_ADD:  val = sum;
                    F3_SLL:
                    begin
                        ok  = (hi6 == SHIFT_HI_LOGIC);
                        val = a << shamt;
                    end
                    F3_SLT:  val = {63'd0, lt_s};
                    F3_SLTU: val = {63'd0, lt_u};
                    F3_XOR:  val = a ^ opb;
                    F3_SR:
                    begin
                        if (hi6 == SHIFT_HI_LOGIC)
                        begin
                            val = a >> shamt;
                        end
                        else if (hi6 == SHIFT_HI_ARITH)
                        begin
                            val = XLEN'($signed(a) >>> shamt);
                        end
                        else
                        begin
                            ok = 1'b0;
                        end
                    end
                    F3_OR:   val = a | opb;
                    default: val = a & opb;
                endcase
            end
            OPC_OP:
            begin
                use1 = 1'b1;
                use2 = 1'b1;
                wr   = 1'b1;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD:  val = sum;
                        F3_SLL:  val = a << shamt;
                        F3_SLT:  val = {63'd0, lt_s};
                        F3_SLTU: val = {63'd0, lt_u};
                        F3_XOR:  val = a ^ opb;
                        F3_SR:   val = a >> shamt;
                        F3_OR:   val = a | opb;
                        default: val = a & opb;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                begin
                    val = diff;
                end
                else if (f7 == F7_ALT && f3 == F3_SR)
                begin
                    val = XLEN'($signed(a) >>> shamt);
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            OPC_OP_32:
            begin
                use1 = 1'b1;
                use2 = 1'b1;
                wr   = 1'b1;
                if (f7 == F7_BASE && f3 == F3_ADD)
                begin
                    val = {{32{w_sum[31]}}, w_sum};
                end
                else if (f7 == F7_BASE && f3 == F3_SLL)
                begin
                    val = {{32{w_sll[31]}}, w_sll};
                end
                else if (f7 == F7_BASE && f3 == F3_SR)
                begin
                    val = {{32{w_srl[31]}}, w_srl};
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                begin
                    val = {{32{w_diff[31]}}, w_diff};
                end
                else if (f7 == F7_ALT && f3 == F3_SR)
                begin
                    val = {{32{w_sra[31]}}, w_sra};
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            OPC_BRANCH:
            begin
                use1 = 1'b1;
                use2 = 1'b1;
                case (f3)
                    F3_BEQ:  cond = (a == b);
                    F3_BNE:  cond = (a != b);
                    F3_BLT:  cond = lt_s;
                    F3_BGE:  cond = !lt_s;
                    F3_BLTU: cond = lt_u;
                    F3_BGEU: cond = !lt_u;
                    default: ok   = 1'b0;
                endcase
                if (cond)
                begin
                    next  = pc + immb;
                    taken = 1'b1;
                end
            end
            OPC_JAL:
            begin
                wr    = 1'b1;
                val   = pc_plus4;
                next  = pc + immj;
                taken = 1'b1;
            end
            OPC_JALR:
            begin
                ok    = (f3 == F3_JALR);
                use1  = 1'b1;
                wr    = 1'b1;
                val   = pc_plus4;
                next  = {sum[XLEN-1:1], 1'b0};
                taken = 1'b1;
            end
            OPC_LUI:
            begin
                wr  = 1'b1;
                val = immu;
            end
            OPC_AUIPC:
            begin
                wr  = 1'b1;
                val = pc + immu;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        if ((use1 && reg_out_of_range(r1)) || (use2 && reg_out_of_range(r2))
            || (wr && reg_out_of_range(rd)))
        begin
            ok = 1'b0;
        end

        if (!ok)
        begin
            result.dest_index   = '0;
            result.dest_write   = 1'b0;
            result.dest_value   = '0;
            result.next_address = pc;
            result.branch_taken = 1'b0;
            result.illegal      = 1'b1;
        end
        else
        begin
            result.dest_index   = wr ? rd : 5'd0;
            result.dest_write   = wr && (rd != 5'd0);
            result.dest_value   = wr ? val : '0;
            result.next_address = next;
            result.branch_taken = taken;
            result.illegal      = 1'b0;
        end
    end

endmodule

### rtl/core/rv64i_integer_execute.sv
// ----------------------------------------------------------------------------
// rv64i_integer_execute
// Executes the RV64I integer subset (OP-IMM, OP, OP-32, branches, JAL, JALR,
// LUI, AUIPC) against a 32 x 64-bit register file and a program counter. One
// instruction is taken per clock unless result_ready stalls the output; it is
// held in ins_reg with registered operands, then its result goes to res_reg.
// The rate is set by the single alu pass into the register file and result
// register. Operands are read from the register file on acceptance, with the
// write executing in that cycle forwarded. An illegal instruction returns
// illegal=1, leaves the pc in next_address and changes no state.
// ----------------------------------------------------------------------------
`include "rv64i_integer_execute_macros.svh"

module rv64i_integer_execute (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        instruction_valid,
    output logic                        instruction_ready,
    input  logic [31:0]                 instruction,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [4:0]                  dest_index,
    output logic                        dest_write,
    output logic [rv64ie_pkg::XLEN-1:0] dest_value,
    output logic [rv64ie_pkg::XLEN-1:0] next_address,
    output logic                        branch_taken,
    output logic                        illegal
);
    import rv64ie_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [31:0]       ins_reg;
    logic [XLEN-1:0]   pc_reg;
    logic [XLEN-1:0]   pc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    exe_result_t       res_reg;
    exe_result_t       exe_res;
    logic              accept;
    logic              fire;
    logic [XLEN-1:0]   rs1_data;
    logic [XLEN-1:0]   rs2_data;

    assign fire              = in_valid_reg && (!out_valid_reg || result_ready);
    assign instruction_ready = !in_valid_reg || fire;
    assign accept            = instruction_valid && instruction_ready;

    rv64ie_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rs1_addr (instruction[15 +: REG_AW]),
        .rs2_addr (instruction[20 +: REG_AW]),
        .wr_en    (fire && exe_res.dest_write),
        .wr_addr  (exe_res.dest_index[REG_AW-1:0]),
        .wr_data  (exe_res.dest_value),
        .rs1_data (rs1_data),
        .rs2_data (rs2_data)
    );

    rv64ie_alu u_alu (
        .instruction (ins_reg),
        .pc          (pc_reg),
        .rs1_data    (rs1_data),
        .rs2_data    (rs2_data),
        .result      (exe_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end

        pc_next = fire ? exe_res.next_address : pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ins_reg <= instruction;
        end
        if (fire)
        begin
            res_reg <= exe_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign dest_index   = res_reg.dest_index;
    assign dest_write   = res_reg.dest_write;
    assign dest_value   = res_reg.dest_value;
    assign next_address = res_reg.next_address;
    assign branch_taken = res_reg.branch_taken;
    assign illegal      = res_reg.illegal;

    `RV64IE_ASSERT(a_illegal_quiet, result_valid && illegal |-> !dest_write && !branch_taken, "illegal beat with side effects")
    `RV64IE_ASSERT(a_write_nonzero, result_valid && dest_write |-> dest_index != 5'd0, "write flagged for x0")
    `RV64IE_ASSERT_NEXT(a_pc_hold, !fire, $stable(pc_reg), "pc moved without an instruction")
    `RV64IE_ASSERT(a_result_source, $rose(result_valid) |-> $past(fire), "result beat without execution")

endmodule
